// ----- design/base64_stream_decoder_core_assert.svh -----
// Assertion macros for the base64 stream decoder.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef BASE64_STREAM_DECODER_CORE_ASSERT_SVH
`define BASE64_STREAM_DECODER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset
`define B64D_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("b64d check failed");
// Check a property on every clock edge, reset included
`define B64D_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("b64d check failed");
`else
`define B64D_ASSERT(name, clk, rst, prop)
`define B64D_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ----- design/b64d_pkg.sv -----
// Shared types, constants and the character classifier of the base64 decoder.
// No dependencies.
package b64d_pkg;

  localparam int unsigned CountMaxBits = 16;
  localparam int unsigned DefaultCountBits = 16;

  typedef enum logic [1:0] {
    CLS_SEXTET  = 2'd0,
    CLS_PAD     = 2'd1,
    CLS_INVALID = 2'd2
  } b64d_class_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_OK    = 2'd1,
    KIND_ERROR = 2'd2
  } b64d_kind_t;

  typedef struct packed {
    logic [5:0]  value;
    b64d_class_t cls;
  } b64d_char_t;

  // Everything one text character causes, handed from decoder to serializer
  typedef struct packed {
    logic [1:0]      nbytes;
    logic [2:0][7:0] bytes;
    logic            has_end;
    logic            end_ok;
    logic [15:0]     end_count;
  } b64d_bundle_t;

  localparam logic [5:0] SextetPlus  = 6'h3e;
  localparam logic [5:0] SextetSlash = 6'h3f;

  // Map one text character to its 6-bit value and class
  function automatic b64d_char_t b64d_classify(input logic [7:0] ch);
    b64d_char_t r;
    r.value = 6'd0;
    r.cls   = CLS_SEXTET;
    if (ch inside {[8'h41:8'h5a]}) begin
      r.value = 6'(ch - 8'h41);
    end else if (ch inside {[8'h61:8'h7a]}) begin
      r.value = 6'(ch - 8'h61 + 8'd26);
    end else if (ch inside {[8'h30:8'h39]}) begin
      r.value = 6'(ch - 8'h30 + 8'd52);
    end else if (ch == 8'h2b) begin
      r.value = SextetPlus;
    end else if (ch == 8'h2f) begin
      r.value = SextetSlash;
    end else if (ch == 8'h3d) begin
      r.cls = CLS_PAD;
    end else begin
      r.cls = CLS_INVALID;
    end
    return r;
  endfunction

endpackage

// ----- design/b64d_if.sv -----
// Valid/ready channel interfaces for text characters in and results out.
// Depends on nothing.
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       final_char;

  modport source (output valid, output text_char, output final_char, input ready);
  modport sink (input valid, input text_char, input final_char, output ready);
endinterface

interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] byte_count;
  logic        run_end;

  modport source (output valid, output kind, output data_byte, output byte_count,
                  output run_end, input ready);
  modport sink (input valid, input kind, input data_byte, input byte_count,
                input run_end, output ready);
endinterface

// ----- design/b64d_decode.sv -----
// Quartet state and per-character decode: classifies the accepted character,
// updates the quartet/error/count state and forms the result bundle. Uses b64d_pkg.
module b64d_decode
  import b64d_pkg::*;
#(
  parameter int unsigned COUNT_BITS = DefaultCountBits
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   text_char,
  input  logic         final_char,
  output b64d_bundle_t bundle,
  output logic         has_results
);

  localparam int unsigned CntW = (COUNT_BITS < CountMaxBits) ? COUNT_BITS : CountMaxBits;
  localparam logic [CntW-1:0] CntLimit = {CntW{1'b1}};

  logic [1:0]        pos;
  logic              err;
  logic [CntW-1:0]   total;
  logic [2:0][5:0]   held_v;
  b64d_class_t [2:0] held_c;

  b64d_char_t        cur;
  logic [1:0]        nbytes;
  logic              err_next;
  logic [CntW:0]     sum;
  logic [CntW-1:0]   total_sat;
  logic [2:0][7:0]   bytes;

  // Classify and decide how many bytes this character releases
  always_comb begin
    cur      = b64d_classify(text_char);
    nbytes   = 2'd0;
    err_next = err;
    bytes[0] = {held_v[0], held_v[1][5:4]};
    bytes[1] = {held_v[1][3:0], held_v[2][5:2]};
    bytes[2] = {held_v[2][1:0], cur.value};
    if (pos != 2'd3) begin
      if (final_char) begin
        err_next = 1'b1;  // length not a multiple of four
      end
    end else if (!err) begin
      if (!final_char) begin
        if (held_c[0] == CLS_SEXTET && held_c[1] == CLS_SEXTET &&
            held_c[2] == CLS_SEXTET && cur.cls == CLS_SEXTET) begin
          nbytes = 2'd3;
        end else begin
          err_next = 1'b1;
        end
      end else if (held_c[0] != CLS_SEXTET || held_c[1] != CLS_SEXTET) begin
        err_next = 1'b1;
      end else if (held_c[2] == CLS_PAD) begin
        nbytes = 2'd1;
      end else if (held_c[2] == CLS_INVALID) begin
        err_next = 1'b1;
      end else if (cur.cls == CLS_PAD) begin
        nbytes = 2'd2;
      end else if (cur.cls == CLS_INVALID) begin
        err_next = 1'b1;
      end else begin
        nbytes = 2'd3;
      end
    end
  end

  // Saturating byte count
  always_comb begin
    sum       = {1'b0, total} + (CntW+1)'(nbytes);
    total_sat = (sum > {1'b0, CntLimit}) ? CntLimit : sum[CntW-1:0];
  end

  // Result bundle
  always_comb begin
    bundle.nbytes    = nbytes;
    bundle.bytes     = bytes;
    bundle.has_end   = final_char;
    bundle.end_ok    = !err_next;
    bundle.end_count = err_next ? 16'd0 : 16'(total_sat);
    has_results      = final_char || (nbytes != 2'd0);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= 2'd0;
      err   <= 1'b0;
      total <= '0;
    end else if (accept) begin
      if (pos != 2'd3 && !final_char) begin
        pos <= pos + 2'd1;
      end else begin
        pos <= 2'd0;
      end
      if (final_char) begin
        err   <= 1'b0;
        total <= '0;
      end else begin
        err   <= err_next;
        total <= total_sat;
      end
    end
  end

  // Held characters of the current quartet
  always_ff @(posedge clk) begin
    if (accept && pos != 2'd3) begin
      held_v[pos] <= cur.value;
      held_c[pos] <= cur.cls;
    end
  end

endmodule

// ----- design/b64d_serializer.sv -----
// Result register, one-deep waiting register and output sequencer: hands out the bytes and
// end item of each bundle one request per cycle while out_ch is ready. Uses b64d_pkg and the assert macros.
`include "base64_stream_decoder_core_assert.svh"

module b64d_serializer
  import b64d_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_has_results,
  input  b64d_bundle_t in_bundle,
  output logic         in_ready,
  b64d_out_if.source   out_ch
);

  logic         busy;
  logic [1:0]   idx;
  logic [2:0]   cnt;
  b64d_bundle_t bnd;
  logic         pend_full;
  b64d_bundle_t pend;

  logic         take;
  logic         last_one;
  logic         slot_free;
  logic         load;
  logic [2:0]   in_cnt;
  logic [2:0]   pend_cnt;

  // Handshake and sequencing; input only waits on a full waiting register
  always_comb begin
    take      = out_ch.valid && out_ch.ready;
    last_one  = ({1'b0, idx} == cnt - 3'd1);
    slot_free = !busy || (take && last_one);
    in_ready  = !pend_full;
    load      = in_valid && in_ready && in_has_results;
    in_cnt    = {1'b0, in_bundle.nbytes} + {2'b00, in_bundle.has_end};
    pend_cnt  = {1'b0, pend.nbytes} + {2'b00, pend.has_end};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 2'd0;
      cnt       <= 3'd0;
      pend_full <= 1'b0;
    end else if (slot_free) begin
      idx <= 2'd0;
      if (pend_full) begin
        busy      <= 1'b1;
        cnt       <= pend_cnt;
        pend_full <= 1'b0;
      end else if (load) begin
        busy <= 1'b1;
        cnt  <= in_cnt;
      end else begin
        busy <= 1'b0;
      end
    end else begin
      if (take) begin
        idx <= idx + 2'd1;
      end
      if (load) begin
        pend_full <= 1'b1;
      end
    end
  end

  // Bundle storage: waiting bundle moves up first to keep order
  always_ff @(posedge clk) begin
    if (slot_free && pend_full) begin
      bnd <= pend;
    end else if (slot_free && load) begin
      bnd <= in_bundle;
    end
    if (!slot_free && load) begin
      pend <= in_bundle;
    end
  end

  // Present the current request
  always_comb begin
    out_ch.valid      = busy;
    out_ch.run_end    = last_one;
    out_ch.kind       = KIND_BYTE;
    out_ch.data_byte  = 8'd0;
    out_ch.byte_count = 16'd0;
    if (idx < bnd.nbytes) begin
      case (idx)
        2'd0:    out_ch.data_byte = bnd.bytes[0];
        2'd1:    out_ch.data_byte = bnd.bytes[1];
        default: out_ch.data_byte = bnd.bytes[2];
      endcase
    end else if (bnd.end_ok) begin
      out_ch.kind       = KIND_OK;
      out_ch.byte_count = bnd.end_count;
    end else begin
      out_ch.kind = KIND_ERROR;
    end
  end

  `B64D_ASSERT(a_idx_in_range, clk, rst, busy |-> (cnt != 3'd0 && {1'b0, idx} < cnt))
  `B64D_ASSERT(a_hold_on_stall, clk, rst, (busy && !out_ch.ready) |=> (busy && $stable(idx)))
  `B64D_ASSERT(a_new_bundle_at_start, clk, rst, (take && last_one) |=> (!busy || idx == 2'd0))
  `B64D_ASSERT(a_pend_needs_busy, clk, rst, pend_full |-> busy)
  `B64D_ASSERT_ALWAYS(a_quiet_in_reset, clk, $past(rst) |-> !busy)

endmodule

// ----- design/base64_stream_decoder_core.sv -----
// Channel   | Dir | Payload                                   | Per item
// in_ch     | in  | text_char[7:0], final_char                | one text character
// out_ch    | out | kind[1:0], data_byte[7:0], byte_count[15:0], run_end | 0 to 4 requests
//
// A character is decoded in the cycle it is accepted; its results go to the
// result register, or to a one-deep waiting register while that still drains.
// Requests leave one per cycle while out_ch.ready is high. in_ch.ready is low
// only while the waiting register is full, so characters are taken every cycle
// unless result-bearing characters arrive faster than out_ch drains their requests.
// rst is synchronous; it clears the quartet state, error flag, count and
// both result slots. A stall on out_ch holds the current request.
// Top level of the base64 stream decoder. Uses b64d_pkg, b64d_if,
// b64d_decode and b64d_serializer.
module base64_stream_decoder_core
  import b64d_pkg::*;
#(
  parameter int unsigned COUNT_BITS = DefaultCountBits
) (
  input logic        clk,
  input logic        rst,
  b64d_in_if.sink    in_ch,
  b64d_out_if.source out_ch
);

  b64d_bundle_t bundle;
  logic         has_results;
  logic         ready;
  logic         accept;

  assign in_ch.ready = ready;
  assign accept      = in_ch.valid && ready;

  // Character decode and quartet state
  b64d_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .text_char   (in_ch.text_char),
    .final_char  (in_ch.final_char),
    .bundle      (bundle),
    .has_results (has_results)
  );

  // Result register and output sequencing
  b64d_serializer u_serializer (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_ch.valid),
    .in_has_results (has_results),
    .in_bundle      (bundle),
    .in_ready       (ready),
    .out_ch         (out_ch)
  );

endmodule

// ----- tb/sv/tb_base64_stream_decoder_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for base64_stream_decoder_core: text characters in,
// decoded bytes and end-of-text status out. Depends on b64d_pkg, b64d_if and base64_stream_decoder_core.
module tb_base64_stream_decoder_core;
  import b64d_pkg::*;

  localparam int CharTarget = 150;   // directed plus random characters
  localparam int CycleLimit = 200000;
  localparam int LongHold   = 300;
  localparam int TailCycles = 16;
  localparam logic [7:0] PadChar = 8'h3d;
  localparam logic [15:0] CountCap =
      (DefaultCountBits >= 16) ? 16'hffff : 16'((1 << DefaultCountBits) - 1);

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_count;
    logic        run_end;
  } decode_result_t;

  // Tracks the decoder state and the results still owed for accepted characters
  class b64_decode_checker;
    decode_result_t expected_results[$];
    logic [1:0]     quartet_pos;
    logic [5:0]     held_val[3];
    b64d_class_t    held_cls[3];
    bit             err_flag;
    logic [15:0]    run_total;
    int             mismatches;
    int             checked;
    int             end_items;

    function new();
      clear_run();
      mismatches = 0;
      checked = 0;
      end_items = 0;
    endfunction

    function void clear_run();
      quartet_pos = 2'd0;
      err_flag = 1'b0;
      run_total = 16'd0;
      for (int i = 0; i < 3; i++) begin
        held_val[i] = 6'd0;
        held_cls[i] = CLS_SEXTET;
      end
    endfunction

    // Alphabet lookup: letters, digits, '+', '/', then pad; all else invalid
    function void classify(input logic [7:0] c, output logic [5:0] v,
                           output b64d_class_t k);
      v = 6'd0;
      k = CLS_SEXTET;
      if (c >= 8'h41 && c <= 8'h5a) v = 6'(c - 8'h41);
      else if (c >= 8'h61 && c <= 8'h7a) v = 6'(c - 8'h61 + 8'd26);
      else if (c >= 8'h30 && c <= 8'h39) v = 6'(c - 8'h30 + 8'd52);
      else if (c == 8'h2b) v = 6'h3e;
      else if (c == 8'h2f) v = 6'h3f;
      else if (c == PadChar) k = CLS_PAD;
      else k = CLS_INVALID;
    endfunction

    function void push(logic [1:0] k, logic [7:0] d, logic [15:0] n);
      decode_result_t r;
      r.kind = k;
      r.data_byte = d;
      r.byte_count = n;
      r.run_end = 1'b0;
      expected_results.push_back(r);
    endfunction

    // Advance the quartet state by one accepted character
    function void note_char(input logic [7:0] c, input logic last);
      logic [5:0]  v;
      b64d_class_t k;
      logic [7:0]  bytes[3];
      int          nb;
      int          prior_size;
      prior_size = expected_results.size();
      nb = 0;
      classify(c, v, k);
      if (quartet_pos < 2'd3) begin
        if (!last) begin
          held_val[quartet_pos] = v;
          held_cls[quartet_pos] = k;
          quartet_pos++;
          return;
        end
        // text ends inside a quartet
        err_flag = 1'b1;
      end else if (!err_flag) begin
        bytes[0] = {held_val[0], held_val[1][5:4]};
        bytes[1] = {held_val[1][3:0], held_val[2][5:2]};
        bytes[2] = {held_val[2][1:0], v};
        if (!last) begin
          if (held_cls[0] == CLS_SEXTET && held_cls[1] == CLS_SEXTET &&
              held_cls[2] == CLS_SEXTET && k == CLS_SEXTET) nb = 3;
          else err_flag = 1'b1;
        end else if (held_cls[0] != CLS_SEXTET || held_cls[1] != CLS_SEXTET) begin
          err_flag = 1'b1;
        end else if (held_cls[2] == CLS_PAD) begin
          nb = 1;   // fourth character not looked at
        end else if (held_cls[2] == CLS_INVALID) begin
          err_flag = 1'b1;
        end else if (k == CLS_PAD) begin
          nb = 2;
        end else if (k == CLS_INVALID) begin
          err_flag = 1'b1;
        end else begin
          nb = 3;
        end
        for (int i = 0; i < nb; i++) begin
          push(KIND_BYTE, bytes[i], 16'd0);
          if (run_total < CountCap) run_total++;
        end
      end
      quartet_pos = 2'd0;
      if (last) begin
        if (err_flag) push(KIND_ERROR, 8'd0, 16'd0);
        else push(KIND_OK, 8'd0, run_total);
        clear_run();
      end
      if (expected_results.size() > prior_size)
        expected_results[expected_results.size() - 1].run_end = 1'b1;
    endfunction

    function void report(string what, decode_result_t e, decode_result_t g);
      if (mismatches < 10) begin
        $display("[%0t] %s: exp kind=%0d byte=%02h count=%0d end=%0b",
                 $time, what, e.kind, e.data_byte, e.byte_count, e.run_end);
        $display("    got kind=%0d byte=%02h count=%0d end=%0b",
                 g.kind, g.data_byte, g.byte_count, g.run_end);
      end
      mismatches++;
    endfunction

    function void check_result(decode_result_t got);
      decode_result_t e;
      checked++;
      if (expected_results.size() == 0) begin
        e = '{default: 'x};
        report("unexpected request", e, got);
        return;
      end
      e = expected_results.pop_front();
      if (e.kind != KIND_BYTE) end_items++;
      if (got.kind !== e.kind || got.data_byte !== e.data_byte ||
          got.byte_count !== e.byte_count || got.run_end !== e.run_end)
        report("mismatch", e, got);
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   chars_sent = 0;
  int   texts_sent = 0;
  bit   calm = 1'b0;
  bit   hold_request = 1'b0;
  b64_decode_checker sb = new();

  b64d_in_if  in_ch();
  b64d_out_if out_ch();

  base64_stream_decoder_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d requests still owed",
               cycle_count, sb.expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 26) return 8'h41 + 8'(v);
    if (v < 52) return 8'h61 + 8'(v - 26);
    if (v < 62) return 8'h30 + 8'(v - 52);
    return (v == 6'h3e) ? 8'h2b : 8'h2f;
  endfunction

  function automatic void add_str(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // One character request; valid stays high across back-to-back requests
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.text_char <= c;
    in_ch.final_char <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_char(c, last);
    chars_sent++;
  endtask

  task automatic send_text(ref logic [7:0] q[$]);
    for (int i = 0; i < q.size(); i++) send_char(q[i], i == q.size() - 1);
    texts_sent++;
  endtask

  // Hold the input until every owed request has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_results.size() != 0);
  endtask

  // Random text: mostly well formed, some truncated, corrupted or pure noise
  function automatic void build_text(ref logic [7:0] q[$]);
    int mode, nq, pads, cut;
    q.delete();
    mode = $urandom_range(0, 9);
    if (mode == 9) begin
      repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    nq = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 6) : $urandom_range(1, 2);
    repeat ((nq - 1) * 4 + 2) q.push_back(sextet_char(6'($urandom_range(0, 63))));
    pads = $urandom_range(0, 2);
    if (pads == 2) begin
      q.push_back(PadChar);
      q.push_back($urandom_range(0, 1) ? PadChar : 8'($urandom_range(0, 255)));
    end else begin
      q.push_back(sextet_char(6'($urandom_range(0, 63))));
      q.push_back(pads == 1 ? PadChar : sextet_char(6'($urandom_range(0, 63))));
    end
    if (mode == 7) begin
      cut = $urandom_range(1, 3);
      repeat (cut) void'(q.pop_back());
    end else if (mode == 8) begin
      q[$urandom_range(0, q.size() - 1)] =
          $urandom_range(0, 1) ? PadChar : 8'($urandom_range(0, 255));
    end
  endfunction

  // Result side: random stalls, one long hold-off on request
  initial begin
    decode_result_t got;
    int stall;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = LongHold;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.kind = out_ch.kind;
      got.data_byte = out_ch.data_byte;
      got.byte_count = out_ch.byte_count;
      got.run_end = out_ch.run_end;
      sb.check_result(got);
    end
  end

  initial begin
    logic [7:0] txt[$];
    bit paused;
    paused = 1'b0;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.text_char <= 8'd0;
    in_ch.final_char <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Three bytes, then a last quartet whose third char is pad (fourth ignored)
    txt.delete();
    add_str(txt, "+/9zQQ=");
    txt.push_back(8'hff);
    send_text(txt);
    // Pad in the fourth position: two bytes
    txt.delete();
    add_str(txt, "QUI=");
    send_text(txt);
    // Pad in the first position of the last quartet
    txt.delete();
    add_str(txt, "=AAA");
    send_text(txt);
    // Invalid character in an inner quartet, later bytes suppressed
    txt.delete();
    add_str(txt, "Zm");
    txt.push_back(8'h00);
    add_str(txt, "vAAAA");
    send_text(txt);
    // Length not a multiple of four
    txt.delete();
    add_str(txt, "Q");
    send_text(txt);

    drain();
    hold_request = 1'b1;

    while (chars_sent < CharTarget) begin
      calm = ($urandom_range(0, 3) == 0);
      build_text(txt);
      send_text(txt);
      if (!paused && chars_sent > CharTarget / 2) begin
        paused = 1'b1;
        drain();
      end
    end

    calm = 1'b0;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_results.size() != 0);
    repeat (TailCycles) @(posedge clk);

    $display("Sent %0d characters in %0d texts; checked %0d requests, %0d of them end status",
             chars_sent, texts_sent, sb.checked, sb.end_items);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- base64_stream_decoder_core.f -----
+incdir+design
design/b64d_pkg.sv
design/b64d_if.sv
design/b64d_decode.sv
design/b64d_serializer.sv
design/base64_stream_decoder_core.sv
tb/sv/tb_base64_stream_decoder_core.sv
